### src/hot_pkg.sv
package hot_pkg;

   // Default sizing
   localparam int NUM_BINS_DEF    = 256;
   localparam int COUNT_WIDTH_DEF = 32;

   // Fixed field widths
   localparam int VOXEL_W     = 16;
   localparam int RANGE_BITS  = 11;   // counted voxels lie in 0..2047
   localparam int THR_W       = 8;
   localparam int OUT_CNT_W   = 32;
   localparam int BIN_PROD_W  = 23;   // 11-bit sample times bin count up to 2048

   typedef struct packed {
      logic signed [VOXEL_W-1:0] voxel;
      logic                      last_voxel;
   } hot_req_type;

   typedef struct packed {
      logic [THR_W-1:0]     threshold_bin;
      logic [OUT_CNT_W-1:0] counted_voxels;
   } hot_rsp_type;

   typedef enum logic [2:0] {
      MUL_A,     // w0 * s1
      MUL_B,     // w1 * s0
      MUL_SQ,    // d * d
      MUL_DEN,   // w0 * w1
      MUL_L,     // sq * best_den
      MUL_R      // best_sq * den
   } mul_op_type;

   typedef enum logic [3:0] {
      S_CLR,
      S_IDLE,
      S_UPD_RD,
      S_UPD_WR,
      S_SW_RD,
      S_SW_ACC,
      S_CHK,
      S_MGO,
      S_MWAIT,
      S_DCHK,
      S_CMP,
      S_BEST,
      S_NEXT,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       mem_rd;
      logic       rd_sel_t;
      logic       upd_wr;
      logic       clr_wr;
      logic       sweep_init;
      logic       acc;
      logic       mul_start;
      mul_op_type mul_op;
      logic       take_best;
      logic       t_inc;
      logic       t_zero;
      logic       emit;
   } hot_cmd_type;

   typedef struct packed {
      logic wzero;
      logic d_zero;
      logic gt;
      logic have;
      logic mul_done;
      logic t_last_thr;
      logic t_last_bin;
      logic rsp_free;
   } hot_sts_type;

endpackage

### src/hot_ctrl.sv
module hot_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              last_voxel,
   input  hot_pkg::hot_sts_type sts,
   output hot_pkg::hot_cmd_type cmd
);
   import hot_pkg::*;

   state_type  state_ff, state_in;
   mul_op_type op_ff, op_in;
   logic       last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         op_ff    <= MUL_A;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         last_ff  <= last_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      last_in  = last_ff;
      case (state_ff)
         S_CLR: begin
            if (sts.t_last_bin) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_UPD_RD;
               last_in  = last_voxel;
            end
         end
         S_UPD_RD: state_in = S_UPD_WR;
         S_UPD_WR: state_in = last_ff ? S_SW_RD : S_IDLE;
         S_SW_RD:  state_in = S_SW_ACC;
         S_SW_ACC: state_in = S_CHK;
         S_CHK: begin
            if (sts.wzero) begin
               state_in = S_NEXT;
            end else begin
               state_in = S_MGO;
               op_in    = MUL_A;
            end
         end
         S_MGO: state_in = S_MWAIT;
         S_MWAIT: begin
            if (sts.mul_done) begin
               case (op_ff)
                  MUL_A: begin
                     state_in = S_MGO;
                     op_in    = MUL_B;
                  end
                  MUL_B:  state_in = S_DCHK;
                  MUL_SQ: begin
                     state_in = S_MGO;
                     op_in    = MUL_DEN;
                  end
                  MUL_DEN: begin
                     // no stored maximum yet: take this one directly
                     state_in = S_BEST;
                     op_in    = MUL_L;
                  end
                  MUL_L: begin
                     state_in = S_MGO;
                     op_in    = MUL_R;
                  end
                  MUL_R:   state_in = S_CMP;
                  default: state_in = S_NEXT;
               endcase
            end
         end
         S_DCHK: begin
            if (sts.d_zero) begin
               state_in = S_NEXT;
            end else begin
               state_in = S_MGO;
               op_in    = MUL_SQ;
            end
         end
         S_CMP:  state_in = sts.gt ? S_BEST : S_NEXT;
         S_BEST: state_in = S_NEXT;
         S_NEXT: state_in = sts.t_last_thr ? S_EMIT : S_SW_RD;
         S_EMIT: begin
            if (sts.rsp_free) state_in = S_CLR;
         end
         default: state_in = S_CLR;
      endcase
      // with a stored maximum, compare cross products before taking it
      if (state_ff == S_MWAIT && sts.mul_done && op_ff == MUL_DEN && sts.have) begin
         state_in = S_MGO;
         op_in    = MUL_L;
      end
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      cmd.mul_op = op_ff;
      req_ready  = 1'b0;
      case (state_ff)
         S_CLR: begin
            cmd.clr_wr = 1'b1;
            cmd.t_inc  = 1'b1;
         end
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_UPD_RD: cmd.mem_rd = 1'b1;
         S_UPD_WR: begin
            cmd.upd_wr     = 1'b1;
            cmd.sweep_init = last_ff;
         end
         S_SW_RD: begin
            cmd.mem_rd   = 1'b1;
            cmd.rd_sel_t = 1'b1;
         end
         S_SW_ACC:  cmd.acc = 1'b1;
         S_MGO:     cmd.mul_start = 1'b1;
         S_BEST:    cmd.take_best = 1'b1;
         S_NEXT:    cmd.t_inc = !sts.t_last_thr;
         S_EMIT: begin
            cmd.emit   = sts.rsp_free;
            cmd.t_zero = sts.rsp_free;
         end
         default: cmd = cmd;
      endcase
   end

endmodule

### src/hot_dp.sv
module hot_dp #(
   parameter int NUM_BINS    = hot_pkg::NUM_BINS_DEF,
   parameter int COUNT_WIDTH = hot_pkg::COUNT_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hot_pkg::hot_req_type req_payload,
   input  hot_pkg::hot_cmd_type cmd,
   output hot_pkg::hot_sts_type sts,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hot_pkg::hot_rsp_type rsp_payload
);
   import hot_pkg::*;

   localparam int BW = (NUM_BINS > 2) ? $clog2(NUM_BINS) : 1;
   localparam int CW = COUNT_WIDTH;
   localparam int SW = CW + BW;          // index sums
   localparam int PW = CW + SW;          // w*s products and their difference
   localparam int LW = 2 * PW + 2 * CW;  // cross products
   localparam logic [CW-1:0] CAP = '1;

   // Histogram store
   logic [CW-1:0] mem [NUM_BINS];
   logic [CW-1:0] rd_data_ff;

   // Voxel capture
   logic [BW-1:0] bin_ff;
   logic          ok_ff;
   logic [BIN_PROD_W-1:0] bin_prod;
   logic          in_range;

   // Accumulators
   logic [CW-1:0] total_ff, w0_ff;
   logic [SW-1:0] isum_ff, s0_ff;
   logic [BW-1:0] t_ff, best_t_ff;
   logic [CW-1:0] w1;
   logic [SW-1:0] s1;

   // Products
   logic [PW-1:0]   a_ff, d_ff, b_val;
   logic [2*PW-1:0] sq_ff, best_sq_ff;
   logic [2*CW-1:0] den_ff, best_den_ff;
   logic [LW-1:0]   lhs_ff;
   logic            gt_ff, have_ff;

   // Shift-add multiplier
   logic [LW-1:0] acc_ff, mcand_ff;
   logic [PW-1:0] mplier_ff;
   logic          busy_ff;
   mul_op_type    mop_ff;

   // Output register
   logic        rsp_valid_ff;
   hot_rsp_type rsp_ff;
   logic [CW+OUT_CNT_W-1:0] tot_x;

   assign in_range = (req_payload.voxel[VOXEL_W-1:RANGE_BITS] == '0);
   assign bin_prod = BIN_PROD_W'(req_payload.voxel[RANGE_BITS-1:0])
                   * BIN_PROD_W'(NUM_BINS);
   assign w1       = total_ff - w0_ff;
   assign s1       = isum_ff - s0_ff;
   assign b_val    = acc_ff[PW-1:0];
   assign tot_x    = (CW + OUT_CNT_W)'(total_ff);

   // Store read and write
   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[cmd.rd_sel_t ? t_ff : bin_ff];
      end
      if (cmd.upd_wr && ok_ff) begin
         mem[bin_ff] <= rd_data_ff + CW'(1);
      end else if (cmd.clr_wr) begin
         mem[t_ff] <= '0;
      end
   end

   // Voxel capture and running totals
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         bin_ff <= BW'(bin_prod >> RANGE_BITS);
         ok_ff  <= in_range && (total_ff < CAP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         isum_ff  <= '0;
         t_ff     <= '0;
         have_ff  <= 1'b0;
      end else begin
         if (cmd.clr_wr) begin
            total_ff <= '0;
            isum_ff  <= '0;
         end else if (cmd.upd_wr && ok_ff) begin
            total_ff <= total_ff + CW'(1);
            isum_ff  <= isum_ff + SW'(bin_ff);
         end
         if (cmd.sweep_init || cmd.t_zero) begin
            t_ff <= '0;
         end else if (cmd.t_inc) begin
            t_ff <= t_ff + BW'(1);
         end
         if (cmd.sweep_init) begin
            have_ff <= 1'b0;
         end else if (cmd.take_best) begin
            have_ff <= 1'b1;
         end
      end
   end

   // Class sums for the current threshold
   always_ff @(posedge clock) begin
      if (cmd.sweep_init) begin
         w0_ff     <= '0;
         s0_ff     <= '0;
         best_t_ff <= '0;
      end else begin
         if (cmd.acc) begin
            w0_ff <= w0_ff + rd_data_ff;
            s0_ff <= s0_ff + SW'(t_ff) * SW'(rd_data_ff);
         end
         if (cmd.take_best) begin
            best_t_ff   <= t_ff;
            best_sq_ff  <= sq_ff;
            best_den_ff <= den_ff;
         end
      end
   end

   // Multiplier: one multiplier bit per cycle, ends when the multiplier is spent
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (cmd.mul_start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && mplier_ff == '0) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_start) begin
         acc_ff <= '0;
         mop_ff <= cmd.mul_op;
         case (cmd.mul_op)
            MUL_A: begin
               mcand_ff  <= LW'(s1);
               mplier_ff <= PW'(w0_ff);
            end
            MUL_B: begin
               mcand_ff  <= LW'(s0_ff);
               mplier_ff <= PW'(w1);
            end
            MUL_SQ: begin
               mcand_ff  <= LW'(d_ff);
               mplier_ff <= d_ff;
            end
            MUL_DEN: begin
               mcand_ff  <= LW'(w0_ff);
               mplier_ff <= PW'(w1);
            end
            MUL_L: begin
               mcand_ff  <= LW'(sq_ff);
               mplier_ff <= PW'(best_den_ff);
            end
            MUL_R: begin
               mcand_ff  <= LW'(best_sq_ff);
               mplier_ff <= PW'(den_ff);
            end
            default: begin
               mcand_ff  <= '0;
               mplier_ff <= '0;
            end
         endcase
      end else if (busy_ff && mplier_ff != '0) begin
         if (mplier_ff[0]) acc_ff <= acc_ff + mcand_ff;
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
      end
   end

   // Product destinations
   always_ff @(posedge clock) begin
      if (busy_ff && mplier_ff == '0) begin
         case (mop_ff)
            MUL_A:   a_ff   <= acc_ff[PW-1:0];
            MUL_B:   d_ff   <= (a_ff >= b_val) ? a_ff - b_val : b_val - a_ff;
            MUL_SQ:  sq_ff  <= acc_ff[2*PW-1:0];
            MUL_DEN: den_ff <= acc_ff[2*CW-1:0];
            MUL_L:   lhs_ff <= acc_ff;
            MUL_R:   gt_ff  <= lhs_ff > acc_ff;
            default: a_ff   <= a_ff;
         endcase
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.threshold_bin  <= THR_W'(best_t_ff);
         rsp_ff.counted_voxels <= (|tot_x[CW+OUT_CNT_W-1:OUT_CNT_W]) ? '1
                                  : tot_x[OUT_CNT_W-1:0];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Status to the controller
   assign sts.wzero      = (w0_ff == '0) || (w1 == '0);
   assign sts.d_zero     = (d_ff == '0);
   assign sts.gt         = gt_ff;
   assign sts.have       = have_ff;
   assign sts.mul_done   = busy_ff && (mplier_ff == '0);
   assign sts.t_last_thr = (t_ff == BW'(NUM_BINS - 2));
   assign sts.t_last_bin = (t_ff == BW'(NUM_BINS - 1));
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule

### src/histogram_otsu_threshold.sv
// Channel   Dir  Handshake               Payload
// req       in   req_valid / req_ready   voxel, last_voxel
// rsp       out  rsp_valid / rsp_ready   threshold_bin, counted_voxels
//
// Each voxel is accepted, read from the store and written back before the next is taken.
// On the last voxel the threshold sweep runs NUM_BINS-1 steps; each step runs up to
// six shift-add multiplies, one multiplier bit per cycle.
// After reset and after each result a clearing pass over all NUM_BINS bins runs with
// req_ready low. A result waiting in the output register stalls only the next result.
module histogram_otsu_threshold #(
   parameter int NUM_BINS    = hot_pkg::NUM_BINS_DEF,
   parameter int COUNT_WIDTH = hot_pkg::COUNT_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hot_pkg::hot_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hot_pkg::hot_rsp_type rsp_payload
);
   import hot_pkg::*;

   hot_cmd_type cmd;
   hot_sts_type sts;

   // Sequencer
   hot_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .last_voxel (req_payload.last_voxel),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Histogram, sums and multiplier
   hot_dp #(
      .NUM_BINS    (NUM_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
